[rtl/vrt_pkg.sv]
// ----------------------------------------------------------------------------
// vrt_pkg
// shared types and constants of the voxel ray traversal block
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int unsigned GRID_BITS_DEF = 4;
  localparam int unsigned FRAC_BITS_DEF = 12;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned VOX_W   = 4;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] start_z;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COORD_W-1:0] end_z;
  } in_word_t;

  typedef struct packed {
    logic [VOX_W-1:0] voxel_x;
    logic [VOX_W-1:0] voxel_y;
    logic [VOX_W-1:0] voxel_z;
    logic             is_last;
  } out_word_t;

endpackage

[rtl/voxel_ray_traversal.sv]
// ----------------------------------------------------------------------------
// voxel_ray_traversal
// walks a segment through the voxel grid and emits every voxel it passes
// ----------------------------------------------------------------------------
//  channel | ports                         | word
//  --------+-------------------------------+------------------------------
//  input   | in_valid, in_stall, in_data   | segment start and end points
//  output  | out_valid, out_stall, out_data| one visited voxel, last flag
//
//  the segment word is set up in its accept cycle, the start voxel is shown
//  in the next cycle; each further voxel is chosen by the axis
//  picker, which shares one multiplier for the crossing time compares
//  a new segment is taken only after the last voxel word has left
//  a stall on the output holds the current voxel word and the whole walk
//  reset clears the sequencer and the output valid
// ----------------------------------------------------------------------------
module voxel_ray_traversal #(
  parameter int unsigned GRID_BITS = vrt_pkg::GRID_BITS_DEF,
  parameter int unsigned FRAC_BITS = vrt_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vrt_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vrt_pkg::out_word_t out_data
);
  import vrt_pkg::*;

  localparam int unsigned TotW  = GRID_BITS + FRAC_BITS;
  localparam int unsigned NumW  = TotW + 1;
  localparam int unsigned ProdW = NumW + TotW;
  localparam int unsigned SumW  = GRID_BITS + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_PICK,
    S_MUL1,
    S_MUL2,
    S_CMP,
    S_MOVE
  } state_t;

  state_t               state_r;
  logic                 out_valid_r;
  logic [GRID_BITS-1:0] cur_r  [3];
  logic                 up_r   [3];
  logic [GRID_BITS-1:0] left_r [3];
  logic [TotW-1:0]      den_r  [3];
  logic [NumW-1:0]      num_r  [3];
  logic [SumW-1:0]      total_r;
  logic [1:0]           cand_r;
  logic [1:0]           best_r;
  logic                 best_vld_r;
  logic [ProdW-1:0]     p1_r;
  logic [ProdW-1:0]     p2_r;

  logic [TotW-1:0]      s_in   [3];
  logic [TotW-1:0]      e_in   [3];
  logic [GRID_BITS-1:0] cv_in  [3];
  logic [GRID_BITS-1:0] ev_in  [3];
  logic                 up_in  [3];
  logic [GRID_BITS-1:0] left_in[3];
  logic [TotW-1:0]      den_in [3];
  logic [NumW-1:0]      num_in [3];
  logic [SumW-1:0]      total_in;

  logic [NumW-1:0]      mul_a;
  logic [TotW-1:0]      mul_b;
  logic [ProdW-1:0]     prod;
  logic                 in_take;
  logic                 out_take;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  assign out_data.voxel_x = VOX_W'(cur_r[0]);
  assign out_data.voxel_y = VOX_W'(cur_r[1]);
  assign out_data.voxel_z = VOX_W'(cur_r[2]);
  assign out_data.is_last = (total_r == '0);

  // per axis set up from the incoming word
  always_comb begin
    s_in[0] = TotW'(in_data.start_x);
    s_in[1] = TotW'(in_data.start_y);
    s_in[2] = TotW'(in_data.start_z);
    e_in[0] = TotW'(in_data.end_x);
    e_in[1] = TotW'(in_data.end_y);
    e_in[2] = TotW'(in_data.end_z);
    for (int a = 0; a < 3; a++) begin
      cv_in[a]   = s_in[a][TotW-1:FRAC_BITS];
      ev_in[a]   = e_in[a][TotW-1:FRAC_BITS];
      up_in[a]   = (ev_in[a] > cv_in[a]);
      left_in[a] = up_in[a] ? (ev_in[a] - cv_in[a]) : (cv_in[a] - ev_in[a]);
      den_in[a]  = (e_in[a] >= s_in[a]) ? (e_in[a] - s_in[a]) : (s_in[a] - e_in[a]);
      num_in[a]  = up_in[a]
                 ? (NumW'({cv_in[a], {FRAC_BITS{1'b0}}}) + (NumW'(1) << FRAC_BITS)
                    - NumW'(s_in[a]))
                 : NumW'(s_in[a][FRAC_BITS-1:0]);
    end
    total_in = SumW'(left_in[0]) + SumW'(left_in[1]) + SumW'(left_in[2]);
  end

  // shared multiplier, operands chosen by the sequencer
  always_comb begin
    if (state_r == S_MUL2) begin
      mul_a = num_r[best_r];
      mul_b = den_r[cand_r];
    end else begin
      mul_a = num_r[cand_r];
      mul_b = den_r[best_r];
    end
    prod = ProdW'(mul_a) * ProdW'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      best_vld_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            for (int a = 0; a < 3; a++) begin
              cur_r[a]  <= cv_in[a];
              up_r[a]   <= up_in[a];
              left_r[a] <= left_in[a];
              den_r[a]  <= den_in[a];
              num_r[a]  <= num_in[a];
            end
            total_r     <= total_in;
            out_valid_r <= 1'b1;
            state_r     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_take) begin
            out_valid_r <= 1'b0;
            cand_r      <= 2'd0;
            best_vld_r  <= 1'b0;
            state_r     <= (total_r == '0) ? S_IDLE : S_PICK;
          end
        end
        S_PICK: begin
          priority if (cand_r == 2'd3) begin
            state_r <= S_MOVE;
          end else if (left_r[cand_r] == '0) begin
            cand_r <= cand_r + 2'd1;
          end else if (!best_vld_r) begin
            best_r     <= cand_r;
            best_vld_r <= 1'b1;
            cand_r     <= cand_r + 2'd1;
          end else begin
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1_r    <= prod;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          p2_r    <= prod;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (p1_r < p2_r) begin
            best_r <= cand_r;
          end
          cand_r  <= cand_r + 2'd1;
          state_r <= S_PICK;
        end
        S_MOVE: begin
          cur_r[best_r]  <= up_r[best_r] ? (cur_r[best_r] + GRID_BITS'(1))
                                         : (cur_r[best_r] - GRID_BITS'(1));
          num_r[best_r]  <= num_r[best_r] + (NumW'(1) << FRAC_BITS);
          left_r[best_r] <= left_r[best_r] - GRID_BITS'(1);
          total_r        <= total_r - SumW'(1);
          out_valid_r    <= 1'b1;
          state_r        <= S_EMIT;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
